>>> rtl/core/spcs_pkg.sv
// Shared types and constants for the sprite column span scaler core.
// Used by spcs_span_calc and sprite_column_span_scaler_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spcs_pkg;

    // Field widths
    localparam int ACC_W      = 29;
    localparam int STEP_W     = 22;
    localparam int CENTER_W   = 12;
    localparam int VIEW_W     = 11;
    localparam int COL_W      = 10;
    localparam int INDEX_W    = 6;
    localparam int TEXEL_W    = 8;
    localparam int ROW_W      = 14;
    localparam int START_W    = 10;
    localparam int COUNT_W    = 11;

    // Port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 40;

    // Limits
    localparam logic signed [ROW_W-1:0] ROW_MAX  = 14'sd8191;
    localparam logic [VIEW_W-1:0]       VIEW_MAX = 11'd1024;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RESET = 22'd65536;
    localparam logic [VIEW_W-1:0] VIEW_RESET = 11'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SCALE = 3'd0,
        CFG_ROW_CENTER = 3'd1,
        CFG_VIEW_ROWS  = 3'd2,
        CFG_COLUMN_X   = 3'd3,
        CFG_CLOAKED    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0]          step_scale;
        logic signed [CENTER_W-1:0] row_center;
        logic [VIEW_W-1:0]          view_rows;
        logic [COL_W-1:0]           column_x;
        logic                       cloaked;
    } spcs_cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0]        acc;
        logic signed [ROW_W-1:0] prev_row;
        logic                    stopped;
    } spcs_state_t;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic               translucent;
        logic [TEXEL_W-1:0] color;
        logic [COUNT_W-1:0] row_count;
        logic [START_W-1:0] row_start;
    } spcs_result_t;

endpackage

`default_nettype wire

>>> rtl/core/spcs_span_calc.sv
// Per-texel span arithmetic: accumulator reload/advance, end row, clipping.
// Depends on spcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spcs_span_calc #(
    parameter int FRAC_BITS = 16
) (
    input  spcs_pkg::spcs_cfg_t                  cfg,
    input  spcs_pkg::spcs_state_t                state,
    input  logic                                 segment_first,
    input  logic [spcs_pkg::INDEX_W-1:0]         texel_index,
    input  logic [spcs_pkg::TEXEL_W-1:0]         texel_value,
    output spcs_pkg::spcs_state_t                state_next,
    output logic                                 res_valid,
    output spcs_pkg::spcs_result_t               result
);
    import spcs_pkg::*;

    localparam int IW    = ACC_W - FRAC_BITS;
    localparam int SUM_W = IW + 2;
    localparam int PROD_W = INDEX_W + STEP_W;

    function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W:0] v);
        return v[ACC_W] ? {ACC_W{1'b1}} : v[ACC_W-1:0];
    endfunction

    // Integer part plus center, saturated at the top row limit
    function automatic logic signed [ROW_W-1:0] end_row(
        input logic [ACC_W-1:0]          a,
        input logic signed [CENTER_W-1:0] rc
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] lim;
        lim = SUM_W'(ROW_MAX);
        s = $signed({2'b00, a[ACC_W-1:FRAC_BITS]}) + SUM_W'(rc);
        return (s > lim) ? ROW_MAX : s[ROW_W-1:0];
    endfunction

    logic [PROD_W-1:0]          prod;
    logic [ACC_W-1:0]           first_acc;
    logic [VIEW_W-1:0]          view_eff;
    logic signed [ROW_W-1:0]    view_s;
    logic [ACC_W-1:0]           base_acc;
    logic signed [ROW_W-1:0]    base_prev;
    logic                       base_stop;
    logic [ACC_W:0]             sum_acc;
    logic [ACC_W-1:0]           new_acc;
    logic signed [ROW_W-1:0]    new_end;
    logic signed [ROW_W-1:0]    start_c;
    logic signed [ROW_W-1:0]    stop_c;
    logic signed [ROW_W-1:0]    count;

    assign prod      = PROD_W'(texel_index) * PROD_W'(cfg.step_scale);
    assign first_acc = acc_sat((ACC_W+1)'(prod));
    assign view_eff  = (cfg.view_rows > VIEW_MAX) ? VIEW_MAX : cfg.view_rows;
    assign view_s    = $signed({{(ROW_W-VIEW_W){1'b0}}, view_eff});

    // Segment start reloads the accumulator and end row
    assign base_acc  = segment_first ? first_acc : state.acc;
    assign base_prev = segment_first ? end_row(first_acc, cfg.row_center) : state.prev_row;
    assign base_stop = segment_first ? 1'b0 : state.stopped;

    assign sum_acc = {1'b0, base_acc} + (ACC_W+1)'(cfg.step_scale);
    assign new_acc = acc_sat(sum_acc);
    assign new_end = end_row(new_acc, cfg.row_center);

    assign start_c = base_prev[ROW_W-1] ? '0 : base_prev;
    assign stop_c  = (new_end > view_s) ? view_s : new_end;
    assign count   = stop_c - start_c;

    always_comb
    begin
        state_next.acc      = base_acc;
        state_next.prev_row = base_prev;
        state_next.stopped  = base_stop;
        res_valid           = 1'b0;
        if (!base_stop)
        begin
            if (base_prev >= view_s)
            begin
                state_next.stopped = 1'b1;
            end
            else
            begin
                state_next.acc = new_acc;
                if (new_end[ROW_W-1])
                begin
                    state_next.prev_row = new_end;
                end
                else
                begin
                    state_next.prev_row = stop_c;
                    res_valid = !count[ROW_W-1] && (count != '0);
                end
            end
        end
    end

    assign result.row_start   = start_c[START_W-1:0];
    assign result.row_count   = count[COUNT_W-1:0];
    assign result.color       = texel_value;
    assign result.translucent = cfg.cloaked;
    assign result.column      = cfg.column_x;

endmodule

`default_nettype wire

>>> rtl/core/sprite_column_span_scaler_core.sv
// Top level of the sprite column span scaler: stream ports, config registers,
// input and result registers. Depends on spcs_pkg and spcs_span_calc.
//
// Scales one sprite column vertically, one texel word per cycle unless the
// span output stalls. A word with tuser set opens a segment and reloads the
// 13.16 accumulator with texel_index * step_scale; every texel then adds
// step_scale, and the screen rows between the previous and the new end row,
// clipped to [0, view_rows) with view_rows capped at 1024, go out as one span
// word. Texels of a segment whose span starts at or below the view bottom are
// dropped, as are empty spans, so a texel gives zero or one output word. The
// accumulator, end row and clip all close in the single compute step between
// the input register and the result register, so the state loop never stalls
// the stream. The span word is loaded into the result register as its texel
// leaves the input register. Write configuration only while no words are in
// flight; writes take effect on the next texel.
`timescale 1ns / 1ps
`default_nettype none

module sprite_column_span_scaler_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [spcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Texel stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spcs_pkg::S_DATA_W-1:0]       s_tdata,   // texel_index[5:0], texel_value[13:6], pad
    input  logic                                s_tuser,   // segment_first
    // Span stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spcs_pkg::M_DATA_W-1:0]       m_tdata,   // row_start[9:0], row_count[20:10],
                                                           // color[28:21], column[38:29], pad
    output logic                                m_tuser    // translucent
);
    import spcs_pkg::*;

    // Configuration registers
    spcs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_scale <= STEP_RESET;
            cfg_reg.row_center <= '0;
            cfg_reg.view_rows  <= VIEW_RESET;
            cfg_reg.column_x   <= '0;
            cfg_reg.cloaked    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_SCALE: cfg_reg.step_scale <= cfg_data[STEP_W-1:0];
                CFG_ROW_CENTER: cfg_reg.row_center <= $signed(cfg_data[CENTER_W-1:0]);
                CFG_VIEW_ROWS:  cfg_reg.view_rows  <= cfg_data[VIEW_W-1:0];
                CFG_COLUMN_X:   cfg_reg.column_x   <= cfg_data[COL_W-1:0];
                CFG_CLOAKED:    cfg_reg.cloaked    <= cfg_data[0];
                default:        ;   // unused index: drop the write
            endcase
        end
    end

    // Input register
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                in_first_reg;
    logic [INDEX_W-1:0]  in_index_reg;
    logic [TEXEL_W-1:0]  in_value_reg;
    logic                s_accept;
    logic                advance;

    // Result register and column state
    logic                out_valid_reg;
    logic                out_valid_next;
    spcs_result_t        res_reg;
    spcs_state_t         state_reg;

    spcs_state_t         state_next;
    logic                calc_valid;
    spcs_result_t        calc_result;

    // Move a texel through compute whenever the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || advance;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = calc_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload: hold when stalled, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_first_reg <= s_tuser;
            in_index_reg <= s_tdata[INDEX_W-1:0];
            in_value_reg <= s_tdata[INDEX_W+TEXEL_W-1:INDEX_W];
        end
        if (advance && calc_valid)
        begin
            res_reg <= calc_result;
        end
    end

    spcs_span_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .segment_first (in_first_reg),
        .texel_index   (in_index_reg),
        .texel_value   (in_value_reg),
        .state_next    (state_next),
        .res_valid     (calc_valid),
        .result        (calc_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.column, res_reg.color, res_reg.row_count,
                       res_reg.row_start};
    assign m_tuser  = res_reg.translucent;

endmodule

`default_nettype wire

>>> rtl/core/spcs_checker.sv
// Port-level checks for sprite_column_span_scaler_core, bound to the top level.
// Depends on spcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spcs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spcs_pkg::M_DATA_W-1:0]   m_tdata
);
    import spcs_pkg::*;

    logic [COUNT_W:0] span_end;
    assign span_end = {2'b00, m_tdata[START_W-1:0]}
                    + {1'b0, m_tdata[START_W+COUNT_W-1:START_W]};

    // Output is empty on the edge after any cycle spent in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("span word valid during reset");

    // Stalled span word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("span word changed while stalled");

    // Every span is non-empty and lies inside the largest view (VIEW_MAX rows)
    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[START_W+COUNT_W-1:START_W] != '0) &&
                     (span_end <= (COUNT_W+1)'(VIEW_MAX)))
        else $error("span outside view or empty");

    // An empty result slot never blocks the texel stream
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind sprite_column_span_scaler_core spcs_checker u_spcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_sprite_column_span_scaler_core.sv
// Self-checking bench for sprite_column_span_scaler_core: texel words in, span words out.
// Keeps its own span tracker and compares every output word against it.
// Depends on spcs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_sprite_column_span_scaler_core;

    import spcs_pkg::*;

    localparam int FRAC        = 16;
    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 100;

    // Span word layout, from the lowest bit up
    localparam int COUNT_LSB  = START_W;
    localparam int COLOR_LSB  = COUNT_LSB + COUNT_W;
    localparam int COLUMN_LSB = COLOR_LSB + TEXEL_W;

    localparam logic [ACC_W-1:0] ACC_TOP = {ACC_W{1'b1}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    // Traffic shaping, set by the stimulus thread
    bit tx_steady = 1'b0;   // sender offers words back to back
    bit rx_steady = 1'b0;   // receiver always ready
    bit hold_off  = 1'b0;   // receiver holds tready low, then raises it

    int cycle_count = 0;

    // Tracks the scaler state and the spans still owed by the core.
    class span_tracker;
        logic [STEP_W-1:0]          step_scale;
        logic signed [CENTER_W-1:0] row_center;
        logic [VIEW_W-1:0]          view_rows;
        logic [COL_W-1:0]           column_x;
        logic                       cloaked;

        logic [ACC_W-1:0]           acc;
        int                         prev_row;
        bit                         stopped;

        spcs_result_t               owed_spans[$];
        int                         mismatches;

        function new();
            step_scale = STEP_RESET;
            row_center = '0;
            view_rows  = VIEW_RESET;
            column_x   = '0;
            cloaked    = 1'b0;
            acc        = '0;
            prev_row   = 0;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_STEP_SCALE: step_scale = value[STEP_W-1:0];
                CFG_ROW_CENTER: row_center = value[CENTER_W-1:0];
                CFG_VIEW_ROWS:  view_rows  = value[VIEW_W-1:0];
                CFG_COLUMN_X:   column_x   = value[COL_W-1:0];
                CFG_CLOAKED:    cloaked    = value[0];
                default: ;
            endcase
        endfunction

        function logic [ACC_W-1:0] acc_clamp(longint sum);
            return (sum > longint'(ACC_TOP)) ? ACC_TOP : sum[ACC_W-1:0];
        endfunction

        // Screen row where the accumulator lands, pinned at the row ceiling
        function int end_row(logic [ACC_W-1:0] a);
            int r;
            r = int'(a >> FRAC) + int'(row_center);
            return (r > int'(ROW_MAX)) ? int'(ROW_MAX) : r;
        endfunction

        function int pending();
            return owed_spans.size();
        endfunction

        // Advance the scaler by one accepted texel and queue its span, if any.
        function void take_texel(bit first, logic [INDEX_W-1:0] idx, logic [TEXEL_W-1:0] texel);
            int           view;
            int           start;
            int           stop;
            spcs_result_t span;
            view = (view_rows > VIEW_MAX) ? int'(VIEW_MAX) : int'(view_rows);
            if (first) begin
                acc      = acc_clamp(longint'(idx) * longint'(step_scale));
                prev_row = end_row(acc);
                stopped  = 1'b0;
            end
            if (stopped)
                return;
            start = prev_row;
            // span opens at or below the bottom: drop the rest of the segment
            if (start >= view) begin
                stopped = 1'b1;
                return;
            end
            acc      = acc_clamp(longint'(acc) + longint'(step_scale));
            stop     = end_row(acc);
            prev_row = stop;
            // wholly above the view: keep the unclipped end row and go on
            if (stop < 0)
                return;
            if (start < 0)
                start = 0;
            if (stop > view)
                stop = view;
            prev_row = stop;
            if (stop - start <= 0)
                return;
            span.row_start   = start[START_W-1:0];
            span.row_count   = 11'(stop - start);
            span.color       = texel;
            span.translucent = cloaked;
            span.column      = column_x;
            owed_spans.push_back(span);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one span word from the core with the oldest owed span.
        function void match_span(logic [M_DATA_W-1:0] data, logic user);
            spcs_result_t want;
            if (owed_spans.size() == 0) begin
                $error("span word with nothing owed: tdata=%h tuser=%b", data, user);
                mismatches++;
                return;
            end
            want = owed_spans.pop_front();
            check_field("row_start", int'(want.row_start), int'(data[0 +: START_W]));
            check_field("row_count", int'(want.row_count), int'(data[COUNT_LSB +: COUNT_W]));
            check_field("color", int'(want.color), int'(data[COLOR_LSB +: TEXEL_W]));
            check_field("column", int'(want.column), int'(data[COLUMN_LSB +: COL_W]));
            check_field("translucent", int'(want.translucent), int'(user));
        endfunction
    endclass

    span_tracker tracker = new();

    sprite_column_span_scaler_core #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // texel_index, texel_value, pad
        .s_tuser  (s_tuser),   // segment_first
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // row_start, row_count, color, column, pad
        .m_tuser  (m_tuser)    // translucent
    );

    always #5 clk = ~clk;

    // Hard stop in case the core wedges
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("tb_sprite_column_span_scaler_core: done, errors");
            $finish;
        end
    end

    // Check every span word taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_span(m_tdata, m_tuser);
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [TEXEL_W-1:0] rand_texel();
        return TEXEL_W'($urandom_range(0, 255));
    endfunction

    // Receiver: alternate ready runs and stalls, one tready update per cycle outside a hold-off.
    initial
    begin : rx_side
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                // hold tready low long enough to back the core up into its input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_steady)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                m_tready <= 1'b1;
                run_left--;
            end
            else
            begin
                run_left   = $urandom_range(1, 20);
                stall_left = idle_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Offer one texel word, after an optional gap, and hold it until taken.
    task automatic send_texel(bit first, logic [INDEX_W-1:0] idx, logic [TEXEL_W-1:0] texel);
        int gap;
        gap = tx_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {{(S_DATA_W - INDEX_W - TEXEL_W){1'b0}}, texel, idx};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_texel(first, idx, texel);
    endtask

    // Stop offering and wait until every owed span is out and the pipe is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic apply_config(logic [STEP_W-1:0] step, logic signed [CENTER_W-1:0] center,
                                logic [VIEW_W-1:0] view, logic [COL_W-1:0] col, logic cloak);
        write_reg(CFG_STEP_SCALE, CFG_DATA_W'(step));
        write_reg(CFG_ROW_CENTER, CFG_DATA_W'($unsigned(center)));
        write_reg(CFG_VIEW_ROWS, CFG_DATA_W'(view));
        write_reg(CFG_COLUMN_X, CFG_DATA_W'(col));
        write_reg(CFG_CLOAKED, CFG_DATA_W'(cloak));
        cfg_we <= 1'b0;
    endtask

    // Random settings, biased to scales that give several spans per segment
    task automatic pick_config();
        logic [STEP_W-1:0]          step;
        logic signed [CENTER_W-1:0] center;
        logic [VIEW_W-1:0]          view;
        int                         r;
        r = $urandom_range(0, 9);
        if (r == 0)
            step = STEP_W'($urandom_range(0, 4194303));
        else if (r == 1)
            step = {STEP_W{1'b1}};
        else if (r == 2)
            step = STEP_W'($urandom_range(0, 255));
        else
            step = STEP_W'($urandom_range(8192, 262144));
        r = $urandom_range(0, 9);
        if (r == 0)
            center = 12'sh800;
        else if (r == 1)
            center = 12'sh7FF;
        else if (r == 2)
            center = CENTER_W'($urandom_range(0, 4095));
        else
            center = CENTER_W'($urandom_range(0, 600) - 300);
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: view = '0;
                1: view = 11'd1;
                2: view = VIEW_MAX;
                default: view = {VIEW_W{1'b1}};
            endcase
        end
        else if (r == 1)
            view = VIEW_W'($urandom_range(1025, 2047));
        else
            view = VIEW_W'($urandom_range(20, 1024));
        apply_config(step, center, view, COL_W'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)));
    endtask

    // Mostly whole segments with random content, some stray words; open with a
    // few continuation texels so the old segment runs on under the new settings.
    task automatic run_phase(int words, int pause_at);
        int sent;
        int len;
        bit paused;
        sent   = $urandom_range(0, 4);
        paused = 1'b0;
        repeat (sent) send_texel(1'b0, rand_index(), rand_texel());
        while (sent < words)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_texel(1'($urandom_range(0, 1)), rand_index(), rand_texel());
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 24);
                send_texel(1'b1, rand_index(), rand_texel());
                repeat (len - 1)
                    send_texel(1'b0, rand_index(), rand_texel());
                sent += len;
            end
            // sender pause: let the core run dry mid-stream
            if (pause_at > 0 && !paused && sent >= pause_at)
            begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: texels ahead of any segment, both index extremes
        send_texel(1'b0, 6'd5, 8'h00);
        send_texel(1'b0, 6'd0, 8'hFF);
        send_texel(1'b1, 6'd0, 8'hAA);
        send_texel(1'b0, 6'd63, 8'h55);
        send_texel(1'b1, 6'd63, 8'h01);
        send_texel(1'b0, 6'd21, 8'h80);
        drain();

        // Zero scale: every span is empty
        apply_config('0, '0, VIEW_RESET, '0, 1'b0);
        send_texel(1'b1, 6'd10, 8'h12);
        send_texel(1'b0, 6'd0, 8'h34);
        drain();

        // Largest scale, lowest center, view beyond the cap, translucent:
        // a span above the view, one clipped at the top, one inside the view, then a
        // segment that opens below the bottom and is skipped
        apply_config({STEP_W{1'b1}}, 12'sh800, {VIEW_W{1'b1}}, 10'd1023, 1'b1);
        send_texel(1'b1, 6'd31, 8'hC3);
        send_texel(1'b0, 6'd0, 8'h3C);
        send_texel(1'b0, 6'd63, 8'h7E);
        send_texel(1'b1, 6'd63, 8'h81);
        send_texel(1'b0, 6'd1, 8'h99);
        drain();

        // Zero view rows: nothing may come out
        apply_config(22'd262144, '0, '0, 10'd512, 1'b0);
        send_texel(1'b1, 6'd0, 8'h66);
        send_texel(1'b0, 6'd0, 8'h67);
        drain();

        // One-row view: a single clipped row, then the segment stops
        apply_config(22'd196608, '0, 11'd1, 10'd1, 1'b1);
        send_texel(1'b1, 6'd0, 8'hF0);
        send_texel(1'b0, 6'd0, 8'h0F);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            pick_config();
            tx_steady = (p == 2 || p == 4 || p == 7);
            rx_steady = (p == 2 || p == 7);
            // back-pressure phase: receiver stalls while words keep coming
            if (p == 4)
                hold_off = 1'b1;
            run_phase(PHASE_WORDS, (p == 6) ? PHASE_WORDS / 2 : 0);
            drain();
        end

        repeat (8) @(posedge clk);
        if (tracker.pending() != 0)
            $error("%0d spans never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_sprite_column_span_scaler_core: done, clean");
        else
            $display("tb_sprite_column_span_scaler_core: done, errors");
        $finish;
    end

endmodule
